// ===== hw/rtl/subimage_swap_to_corner_top_assert.svh =====
// Assertion macros shared by the frame swap block
`ifndef SUBIMAGE_SWAP_TO_CORNER_TOP_ASSERT_SVH
`define SUBIMAGE_SWAP_TO_CORNER_TOP_ASSERT_SVH

// same-cycle implication
`define SSWAP_CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSWAP_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sswap_pkg.sv =====
package sswap_pkg;

	localparam int MAX_COLS_DEF   = 64;
	localparam int MAX_ROWS_DEF   = 64;
	localparam int PIXEL_BITS_DEF = 8;

	localparam int CFG_W    = 7;
	localparam int OFS_W    = 6;
	localparam int IDX_W    = CFG_W + 1;
	localparam int FUNC_W   = 2;
	localparam int POS_W    = 6;
	localparam int PIX_IO_W = 8;
	localparam int STATUS_W = 2;
	localparam int REG_IDX_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_WRITE = 2'd0,
		FN_MOVE  = 2'd1,
		FN_READ  = 2'd2
	} func_t;

	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_GEOM_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] STS_ADDR_ERR = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RECT_COLS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RECT_ROWS  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_COL = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_ROW = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_RD      = 4'b0010,
		ST_SWAP_WA = 4'b0100,
		ST_SWAP_WB = 4'b1000
	} state_t;

endpackage

// ===== hw/rtl/sswap_mem.sv =====
// Frame store: one write port, two registered read ports, write-through on collision
module sswap_mem
	import sswap_pkg::*;
#(
	parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF,
	parameter int AW    = 12,
	parameter int DW    = PIXEL_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [DW-1:0] rd_data_a,
	output logic [DW-1:0] rd_data_b
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rda_q;
	logic [DW-1:0] rdb_q;
	logic [DW-1:0] byp_data_q;
	logic          byp_a_q;
	logic          byp_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rda_q      <= mem[rd_addr_a];
		rdb_q      <= mem[rd_addr_b];
		byp_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_a_q <= 1'b0;
			byp_b_q <= 1'b0;
		end else begin
			byp_a_q <= wr_en && (wr_addr == rd_addr_a);
			byp_b_q <= wr_en && (wr_addr == rd_addr_b);
		end
	end

	assign rd_data_a = byp_a_q ? byp_data_q : rda_q;
	assign rd_data_b = byp_b_q ? byp_data_q : rdb_q;

endmodule

// ===== hw/rtl/subimage_swap_to_corner_top.sv =====
// Frame store with a swap-to-corner command.
// Input channel (in_valid/in_stall): func, row, col, pixel_in. func write stores a
// pixel (no result word), func read returns pixel_out/status, func move swaps the
// configured rectangle with the top-left one and returns status. Output channel
// (out_valid/out_stall) carries one word per read or move.
// Per item: a write is stored on acceptance; a read does a registered memory read,
// then loads the output register; a move issues its first pair read on acceptance,
// then two writes per pair on the single write port, with the next pair's read
// overlapping the second write. A refused or empty move answers on acceptance.
// in_stall is high while a read or move runs and while an unaccepted result
// sits in the output register with out_stall high; the output register holds
// its word stable until taken.
// Configuration (cfg_wr_en/cfg_index/cfg_data) is to be written only while idle;
// the block does not enforce this. Reset clears the sequencer and output valid and
// restores the register defaults; pixel contents are undefined until written.
`include "subimage_swap_to_corner_top_assert.svh"

module subimage_swap_to_corner_top
	import sswap_pkg::*;
#(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FUNC_W-1:0]    func,
	input  logic [POS_W-1:0]     row,
	input  logic [POS_W-1:0]     col,
	input  logic [PIX_IO_W-1:0]  pixel_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_IO_W-1:0]  pixel_out,
	output logic [STATUS_W-1:0]  status
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_C = $clog2(MAX_COLS + 1);
	localparam int DIM_R = $clog2(MAX_ROWS + 1);
	localparam int DIM_W = (DIM_C > DIM_R) ? DIM_C : DIM_R;
	localparam int CMP_W = (DIM_W > IDX_W) ? DIM_W : IDX_W;

	function automatic logic [AW-1:0] pix_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		pix_addr = AW'(32'(r) * MAX_COLS + 32'(c));
	endfunction

	state_t state_q;

	logic [CFG_W-1:0] frame_cols_q, frame_rows_q, rect_cols_q, rect_rows_q;
	logic [OFS_W-1:0] offset_col_q, offset_row_q;

	logic [CFG_W-1:0] i_q, j_q;
	logic [AW-1:0]    a_q, b_q;
	logic             last_q;
	logic [PIXEL_BITS-1:0] hold_q;

	logic                 out_valid_q;
	logic [PIX_IO_W-1:0]  pixel_out_q;
	logic [STATUS_W-1:0]  status_q;

	logic                  accept;
	logic                  out_load;
	logic [CMP_W-1:0]      eff_cols, eff_rows;
	logic                  in_frame, fits, rect_empty, pair_last;
	logic [AW-1:0]         addr_in, pair_a, pair_b;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr, rd_addr_a;
	logic [PIXEL_BITS-1:0] wr_data, rd_data_a, rd_data_b;

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign status    = status_q;

	// a result word enters the output register this cycle
	assign out_load = ((state_q == ST_IDLE) && accept
		&& (((func == FN_READ) && !in_frame) || ((func == FN_MOVE) && (!fits || rect_empty))))
		|| (state_q == ST_RD) || ((state_q == ST_SWAP_WB) && last_q);

	always_comb begin
		eff_cols = (CMP_W'(frame_cols_q) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
			: CMP_W'(frame_cols_q);
		eff_rows = (CMP_W'(frame_rows_q) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
			: CMP_W'(frame_rows_q);
		in_frame = (CMP_W'(row) < eff_rows) && (CMP_W'(col) < eff_cols);
		fits = !(CMP_W'(offset_col_q) + CMP_W'(rect_cols_q) > eff_cols)
			&& !(CMP_W'(offset_row_q) + CMP_W'(rect_rows_q) > eff_rows);
		rect_empty = (rect_cols_q == '0) || (rect_rows_q == '0);
		pair_last = (i_q == rect_rows_q - CFG_W'(1)) && (j_q == rect_cols_q - CFG_W'(1));
		addr_in = pix_addr(IDX_W'(row), IDX_W'(col));
		pair_a  = pix_addr(IDX_W'(i_q), IDX_W'(j_q));
		pair_b  = pix_addr(IDX_W'(i_q) + IDX_W'(offset_row_q),
			IDX_W'(j_q) + IDX_W'(offset_col_q));
	end

	// memory port steering
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = addr_in;
		wr_data   = PIXEL_BITS'(pixel_in);
		rd_addr_a = ((state_q == ST_IDLE) && (func == FN_READ)) ? addr_in : pair_a;
		unique case (state_q)
			ST_IDLE: begin
				wr_en = accept && (func == FN_WRITE) && in_frame;
			end
			ST_SWAP_WA: begin
				wr_en   = 1'b1;
				wr_addr = a_q;
				wr_data = rd_data_b;
			end
			ST_SWAP_WB: begin
				wr_en   = 1'b1;
				wr_addr = b_q;
				wr_data = hold_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	sswap_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (PIXEL_BITS)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (pair_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q <= CFG_W'(64);
			frame_rows_q <= CFG_W'(64);
			rect_cols_q  <= CFG_W'(1);
			rect_rows_q  <= CFG_W'(1);
			offset_col_q <= '0;
			offset_row_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_COLS: frame_cols_q <= cfg_data;
				REG_FRAME_ROWS: frame_rows_q <= cfg_data;
				REG_RECT_COLS:  rect_cols_q  <= cfg_data;
				REG_RECT_ROWS:  rect_rows_q  <= cfg_data;
				REG_OFFSET_COL: offset_col_q <= cfg_data[OFS_W-1:0];
				REG_OFFSET_ROW: offset_row_q <= cfg_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			last_q      <= 1'b0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
			pixel_out_q <= '0;
			status_q    <= STS_OK;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			// issue a pair read: latch its addresses, step the counters
			if ((state_q == ST_SWAP_WB && !last_q)
				|| (state_q == ST_IDLE && accept && func == FN_MOVE && fits && !rect_empty)) begin
				a_q    <= pair_a;
				b_q    <= pair_b;
				last_q <= pair_last;
				if (pair_last) begin
					i_q <= '0;
					j_q <= '0;
				end else if (j_q == rect_cols_q - CFG_W'(1)) begin
					j_q <= '0;
					i_q <= i_q + CFG_W'(1);
				end else begin
					j_q <= j_q + CFG_W'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FN_READ: begin
								if (in_frame) begin
									state_q <= ST_RD;
								end else begin
									out_valid_q <= 1'b1;
									pixel_out_q <= '0;
									status_q    <= STS_ADDR_ERR;
								end
							end
							FN_MOVE: begin
								if (!fits) begin
									out_valid_q <= 1'b1;
									pixel_out_q <= '0;
									status_q    <= STS_GEOM_ERR;
								end else if (rect_empty) begin
									out_valid_q <= 1'b1;
									pixel_out_q <= '0;
									status_q    <= STS_OK;
								end else begin
									state_q <= ST_SWAP_WA;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					out_valid_q <= 1'b1;
					pixel_out_q <= PIX_IO_W'(rd_data_a);
					status_q    <= STS_OK;
					state_q     <= ST_IDLE;
				end
				ST_SWAP_WA: begin
					hold_q  <= rd_data_a;
					state_q <= ST_SWAP_WB;
				end
				ST_SWAP_WB: begin
					if (last_q) begin
						out_valid_q <= 1'b1;
						pixel_out_q <= '0;
						status_q    <= STS_OK;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_SWAP_WA;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SSWAP_CHK_SAME(a_busy_out_empty, state_q == ST_RD || state_q == ST_SWAP_WA || state_q == ST_SWAP_WB, !out_valid_q, "output word held while busy")
	`SSWAP_CHK_NEXT(a_wa_then_wb, state_q == ST_SWAP_WA, state_q == ST_SWAP_WB, "swap write order broken")
	`SSWAP_CHK_NEXT(a_last_done, state_q == ST_SWAP_WB && last_q, state_q == ST_IDLE && out_valid_q && status_q == STS_OK, "move did not finish")
	`SSWAP_CHK_SAME(a_out_src, $rose(out_valid_q), $past(state_q) == ST_IDLE || $past(state_q) == ST_RD || $past(state_q) == ST_SWAP_WB, "result word from wrong state")

endmodule
